FILE: sv/chtrk_pkg.sv
// shared types, constants and helpers of the channel hop tracker
package chtrk_pkg;

   localparam int unsigned IDX_W     = 2;
   localparam int unsigned GEN_W     = 6;
   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned HOP_W     = 8;
   localparam int unsigned TABLE_LEN = 4;
   localparam int unsigned ADDR_W    = 5;
   localparam int unsigned DATA_W    = 32;

   typedef enum logic [1:0] {
      ACT_RESTART = 2'd0,
      ACT_OBSERVE = 2'd1,
      ACT_ADVANCE = 2'd2,
      ACT_SCAN    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_SEED      = 3'd0,
      REG_CHANNEL_0 = 3'd1,
      REG_CHANNEL_1 = 3'd2,
      REG_CHANNEL_2 = 3'd3,
      REG_CHANNEL_3 = 3'd4
   } reg_index_type;

   localparam logic [CHAN_W-1:0] CHAN_RESET [TABLE_LEN] = '{8'd1, 8'd6, 8'd11, 8'd0};

   // configuration as seen by the step logic
   typedef struct packed {
      logic [IDX_W-1:0]                    seed_mod;
      logic [TABLE_LEN-1:0][CHAN_W-1:0]    chan;
   } cfg_type;

   // restoring reduction of an 8-bit value by a small channel count
   function automatic logic [IDX_W-1:0] mod_small(logic [7:0] v, int unsigned n);
      logic [8:0] r;
      logic [8:0] sub;
      r = {1'b0, v};
      for (int k = 6; k >= 0; k--) begin
         sub = 9'(n << k);
         if (r >= sub) begin
            r = r - sub;
         end
      end
      return IDX_W'(r);
   endfunction

endpackage

FILE: sv/channel_hop_tracker_core.sv
// top level of the channel hop tracker: state, result register and csr port
//
// usage
// - request channel: req_action (0 restart, 1 observe, 2 advance, 3 scan next)
//   and req_packed_hop (index in bits 7..6, generation below) move in one
//   transfer when req_valid is high and req_stall is low
// - response channel: one transfer per request carrying rsp_moved,
//   rsp_hop_index, rsp_hop_generation and rsp_scan_channel
// - the result of a request is registered: it is presented in the response
//   register from the cycle after the request is taken
// - throughput is one request per cycle while req_stall is low; the step logic
//   between the hop state registers and the response register sets this figure
// - a request is taken while a finished response is still offered, as long
//   as that response is taken in the same cycle
// - when the receiver stalls with a response pending, req_stall is raised
//   and the response and hop state hold
// - reset clears the hop state (index, generation, scan position) and the
//   pending response; csr registers return to seed 0 and channels 1, 6, 11, 0
// - csr writes go through the apb-style port, one register per word
module channel_hop_tracker_core import chtrk_pkg::*; #(
   parameter int unsigned NUM_CHANNELS = 3,
   parameter int unsigned GEN_BITS     = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic [HOP_W-1:0]  req_packed_hop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_moved,
   output logic [IDX_W-1:0]  rsp_hop_index,
   output logic [GEN_W-1:0]  rsp_hop_generation,
   output logic [CHAN_W-1:0] rsp_scan_channel,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type             cfg;

   // hop state
   logic [IDX_W-1:0]    index_ff;
   logic [GEN_BITS-1:0] gen_ff;
   logic [IDX_W-1:0]    scan_ff;
   logic [IDX_W-1:0]    index_in;
   logic [GEN_BITS-1:0] gen_in;
   logic [IDX_W-1:0]    scan_in;

   // response register
   logic                rsp_valid_ff;
   logic                moved_ff;
   logic [CHAN_W-1:0]   chan_ff;
   logic                moved_in;
   logic [CHAN_W-1:0]   chan_in;

   logic                req_take;

   assign pready = 1'b1;

   chtrk_csr #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   chtrk_step #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .GEN_BITS     (GEN_BITS)
   ) u_step (
      .action       (action_type'(req_action)),
      .packed_hop   (req_packed_hop),
      .cur_index    (index_ff),
      .cur_gen      (gen_ff),
      .cur_scan     (scan_ff),
      .cfg          (cfg),
      .nxt_index    (index_in),
      .nxt_gen      (gen_in),
      .nxt_scan     (scan_in),
      .moved        (moved_in),
      .scan_channel (chan_in)
   );

   // stall only while a pending response is itself held back
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff     <= '0;
         gen_ff       <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            index_ff <= index_in;
            gen_ff   <= gen_in;
            scan_ff  <= scan_in;
         end
         if (!req_stall) begin
            rsp_valid_ff <= req_valid;
         end
      end
   end

   // payload captured with each request transfer
   always_ff @(posedge clock) begin
      if (req_take) begin
         moved_ff <= moved_in;
         chan_ff  <= chan_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_moved          = moved_ff;
   assign rsp_hop_index      = index_ff;
   assign rsp_hop_generation = GEN_W'(gen_ff);
   assign rsp_scan_channel   = chan_ff;

endmodule

FILE: sv/chtrk_csr.sv
// configuration registers of the channel hop tracker
module chtrk_csr import chtrk_pkg::*; #(
   parameter int unsigned NUM_CHANNELS = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output cfg_type           cfg
);

   logic [CHAN_W-1:0]                 seed_ff;
   logic [IDX_W-1:0]                  seed_mod_ff;
   logic [TABLE_LEN-1:0][CHAN_W-1:0]  chan_ff;
   logic                              wr_en;
   reg_index_type                     reg_idx;

   assign reg_idx = reg_index_type'(paddr[4:2]);
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= '0;
         seed_mod_ff <= '0;
         for (int i = 0; i < TABLE_LEN; i++) begin
            chan_ff[i] <= CHAN_RESET[i];
         end
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_SEED: begin
               seed_ff     <= pwdata[CHAN_W-1:0];
               // restart index computed once, at write time
               seed_mod_ff <= mod_small(pwdata[CHAN_W-1:0], NUM_CHANNELS);
            end
            REG_CHANNEL_0: chan_ff[0] <= pwdata[CHAN_W-1:0];
            REG_CHANNEL_1: chan_ff[1] <= pwdata[CHAN_W-1:0];
            REG_CHANNEL_2: chan_ff[2] <= pwdata[CHAN_W-1:0];
            REG_CHANNEL_3: chan_ff[3] <= pwdata[CHAN_W-1:0];
            default: ; // writes beyond the list are dropped
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SEED:      prdata = DATA_W'(seed_ff);
         REG_CHANNEL_0: prdata = DATA_W'(chan_ff[0]);
         REG_CHANNEL_1: prdata = DATA_W'(chan_ff[1]);
         REG_CHANNEL_2: prdata = DATA_W'(chan_ff[2]);
         REG_CHANNEL_3: prdata = DATA_W'(chan_ff[3]);
         default:       prdata = '0;
      endcase
   end

   assign cfg.seed_mod = seed_mod_ff;
   assign cfg.chan     = chan_ff;

endmodule

FILE: sv/chtrk_step.sv
// next-state and result logic for one hop event
module chtrk_step import chtrk_pkg::*; #(
   parameter int unsigned NUM_CHANNELS = 3,
   parameter int unsigned GEN_BITS     = 6
) (
   input  action_type          action,
   input  logic [HOP_W-1:0]    packed_hop,
   input  logic [IDX_W-1:0]    cur_index,
   input  logic [GEN_BITS-1:0] cur_gen,
   input  logic [IDX_W-1:0]    cur_scan,
   input  cfg_type             cfg,
   output logic [IDX_W-1:0]    nxt_index,
   output logic [GEN_BITS-1:0] nxt_gen,
   output logic [IDX_W-1:0]    nxt_scan,
   output logic                moved,
   output logic [CHAN_W-1:0]   scan_channel
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

   logic [IDX_W-1:0]    obs_idx;
   logic [GEN_BITS-1:0] obs_gen;
   logic [GEN_BITS-1:0] gen_diff;
   logic                obs_ok;
   logic [IDX_W-1:0]    adv_idx;
   logic [IDX_W-1:0]    scan_inc;

   assign obs_idx  = packed_hop[HOP_W-1 -: IDX_W];
   assign obs_gen  = packed_hop[GEN_BITS-1:0];
   assign gen_diff = obs_gen - cur_gen;
   // newer: valid index and nonzero distance in the lower half of the wrap circle
   assign obs_ok   = ({1'b0, obs_idx} < (IDX_W+1)'(NUM_CHANNELS))
                     && (gen_diff != '0) && !gen_diff[GEN_BITS-1];
   assign adv_idx  = (cur_index == LAST_IDX) ? '0 : cur_index + 1'b1;
   assign scan_inc = (cur_scan == LAST_IDX) ? '0 : cur_scan + 1'b1;

   always_comb begin
      nxt_index = cur_index;
      nxt_gen   = cur_gen;
      nxt_scan  = cur_scan;
      moved     = 1'b0;
      unique case (action)
         ACT_RESTART: begin
            nxt_index = cfg.seed_mod;
            nxt_gen   = '0;
            nxt_scan  = cfg.seed_mod;
         end
         ACT_OBSERVE: begin
            if (obs_ok) begin
               nxt_index = obs_idx;
               nxt_gen   = obs_gen;
               nxt_scan  = obs_idx;
               moved     = (obs_idx != cur_index);
            end
         end
         ACT_ADVANCE: begin
            nxt_index = adv_idx;
            nxt_gen   = cur_gen + 1'b1;
            nxt_scan  = adv_idx;
         end
         ACT_SCAN: begin
            nxt_scan = scan_inc;
         end
         default: ;
      endcase
   end

   assign scan_channel = cfg.chan[nxt_scan];

endmodule

FILE: sv/chtrk_checker.sv
// port-level checks of the channel hop tracker, bound to the top level
module chtrk_checker import chtrk_pkg::*; #(
   parameter int unsigned NUM_CHANNELS = 3
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [1:0]        req_action,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_moved,
   input logic [IDX_W-1:0]  rsp_hop_index,
   input logic [GEN_W-1:0]  rsp_hop_generation,
   input logic [CHAN_W-1:0] rsp_scan_channel
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_moved)
         && $stable(rsp_hop_index) && $stable(rsp_hop_generation)
         && $stable(rsp_scan_channel))
      else $error("stalled response changed");

   // requests are held back only behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   // restart yields generation zero and no move in the next cycle
   a_restart: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (action_type'(req_action) == ACT_RESTART)
         |=> rsp_valid && (rsp_hop_generation == '0) && !rsp_moved)
      else $error("restart response wrong");

   // index always names an existing channel
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_hop_index} < (IDX_W+1)'(NUM_CHANNELS)))
      else $error("hop index out of range");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind channel_hop_tracker_core chtrk_checker #(
   .NUM_CHANNELS (NUM_CHANNELS)
) u_chtrk_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_action         (req_action),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_moved          (rsp_moved),
   .rsp_hop_index      (rsp_hop_index),
   .rsp_hop_generation (rsp_hop_generation),
   .rsp_scan_channel   (rsp_scan_channel)
);
